// ===== rtl/sbsn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sample buffer statistics normalizer.
// Used by sbsn_divider and sample_buffer_stats_normalizer; no dependencies.
package sbsn_pkg;

    localparam int SAMPLE_W = 10;
    localparam int FRAC_W   = 16;
    localparam int NORM_W   = FRAC_W + 1;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = '1;
    localparam logic [SAMPLE_W-1:0] MIN_RESET    = '1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_READ,
        ST_NORM,
        ST_NORM_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/sbsn_divider.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider that retires one quotient bit per cycle.
// Depends on sbsn_pkg for the status struct.
module sbsn_divider #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DVD_W-1:0]     dividend,
    input  logic [DVS_W-1:0]     divisor,
    output sbsn_pkg::div_status_t status,
    output logic [DVD_W-1:0]     quotient
);
    import sbsn_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  work_reg, work_next;
    logic [DVS_W-1:0]  divisor_reg, divisor_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    trial_diff;
    logic              fits;

    assign trial      = {rem_reg, work_reg[DVD_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign fits       = (trial >= {1'b0, divisor_reg});

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        work_next    = work_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            step_next    = STEP_W'(DVD_W);
            rem_next     = '0;
            work_next    = dividend;
            divisor_next = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
            work_next = {work_reg[DVD_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg     <= rem_next;
        work_reg    <= work_next;
        divisor_reg <= divisor_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = work_reg;

endmodule

// ===== rtl/sample_buffer_stats_normalizer.sv =====
`timescale 1ns / 1ps
// Burst buffer with running max, min, sum and threshold flag, and min-max normalization.
// Samples load one beat per cycle while in the load state; after the last beat the shared
// 26-bit divider (one bit per cycle) computes the mean, then each result in turn; a result
// skips the divider when all stored samples are equal.
// Reset clears the statistics and output valid and sets the threshold to 1023.
// The sample memory is not cleared; only entries written in the current burst are read.
module sample_buffer_stats_normalizer #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sbsn_pkg::SAMPLE_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbsn_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbsn_pkg::NORM_W-1:0]   m_normalized,
    output logic [sbsn_pkg::SAMPLE_W-1:0] m_max_value,
    output logic [sbsn_pkg::SAMPLE_W-1:0] m_min_value,
    output logic [sbsn_pkg::SAMPLE_W-1:0] m_mean_value,
    output logic                          m_below_flag,
    output logic                          m_overflow,
    output logic                          m_last_out
);
    import sbsn_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int DVD_W = (SAMPLE_W + FRAC_W > SUM_W) ? (SAMPLE_W + FRAC_W) : SUM_W;
    localparam int DVS_W = (SAMPLE_W > CNT_W) ? SAMPLE_W : CNT_W;

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] thresh_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                below_reg, below_next;
    logic                dropped_reg, dropped_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic [NORM_W-1:0]   norm_reg, norm_next;

    logic                m_valid_reg, m_valid_next;
    logic [NORM_W-1:0]   m_norm_reg, m_norm_next;
    logic [SAMPLE_W-1:0] m_max_reg, m_max_next;
    logic [SAMPLE_W-1:0] m_min_reg, m_min_next;
    logic [SAMPLE_W-1:0] m_mean_reg, m_mean_next;
    logic                m_below_reg, m_below_next;
    logic                m_over_reg, m_over_next;
    logic                m_last_reg, m_last_next;

    logic [SAMPLE_W-1:0] sample_mem [BUFFER_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                store_we;

    logic                in_beat;
    logic                has_room;
    logic [SAMPLE_W-1:0] range;
    logic [SAMPLE_W-1:0] offset;
    logic                final_item;

    logic                div_start;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    div_status_t         div_status;
    logic [DVD_W-1:0]    div_quotient;

    sbsn_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign s_ready    = (state_reg == ST_LOAD);
    assign in_beat    = s_valid && s_ready;
    assign has_room   = (count_reg < CNT_W'(BUFFER_DEPTH));
    assign store_we   = in_beat && has_room;
    assign range      = max_reg - min_reg;
    assign offset     = rd_data_reg - min_reg;
    assign final_item = ((rd_idx_reg + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        sum_next     = sum_reg;
        below_next   = below_reg;
        dropped_next = dropped_reg;
        rd_idx_next  = rd_idx_reg;
        mean_next    = mean_reg;
        norm_next    = norm_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_norm_next  = m_norm_reg;
        m_max_next   = m_max_reg;
        m_min_next   = m_min_reg;
        m_mean_next  = m_mean_reg;
        m_below_next = m_below_reg;
        m_over_next  = m_over_reg;
        m_last_next  = m_last_reg;
        div_start    = 1'b0;
        div_dividend = DVD_W'({offset, {FRAC_W{1'b0}}});
        div_divisor  = DVS_W'(range);

        case (state_reg)
            ST_LOAD: begin
                if (in_beat) begin
                    if (has_room) begin
                        count_next = count_reg + CNT_W'(1);
                        sum_next   = sum_reg + SUM_W'(s_sample);
                        if (s_sample > max_reg) begin
                            max_next = s_sample;
                        end
                        if (s_sample < min_reg) begin
                            min_next = s_sample;
                        end
                        if (s_sample <= thresh_reg) begin
                            below_next = 1'b1;
                        end
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_last) begin
                        state_next = ST_MEAN;
                    end
                end
            end
            ST_MEAN: begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(sum_reg);
                div_divisor  = DVS_W'(count_reg);
                state_next   = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_status.done) begin
                    mean_next  = div_quotient[SAMPLE_W-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (range == '0) begin
                    norm_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_NORM_WAIT;
                end
            end
            ST_NORM_WAIT: begin
                if (div_status.done) begin
                    norm_next  = div_quotient[NORM_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_norm_next  = norm_reg;
                    m_max_next   = max_reg;
                    m_min_next   = min_reg;
                    m_mean_next  = mean_reg;
                    m_below_next = below_reg;
                    m_over_next  = dropped_reg;
                    m_last_next  = final_item;
                    if (final_item) begin
                        count_next   = '0;
                        max_next     = '0;
                        min_next     = MIN_RESET;
                        sum_next     = '0;
                        below_next   = 1'b0;
                        dropped_next = 1'b0;
                        rd_idx_next  = '0;
                        state_next   = ST_LOAD;
                    end else begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg  <= THRESH_RESET;
            count_reg   <= '0;
            max_reg     <= '0;
            min_reg     <= MIN_RESET;
            sum_reg     <= '0;
            below_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                thresh_reg <= cfg_wdata;
            end
            count_reg   <= count_next;
            max_reg     <= max_next;
            min_reg     <= min_next;
            sum_reg     <= sum_next;
            below_reg   <= below_next;
            dropped_reg <= dropped_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
        mean_reg    <= mean_next;
        norm_reg    <= norm_next;
        m_norm_reg  <= m_norm_next;
        m_max_reg   <= m_max_next;
        m_min_reg   <= m_min_next;
        m_mean_reg  <= m_mean_next;
        m_below_reg <= m_below_next;
        m_over_reg  <= m_over_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            sample_mem[count_reg[IDX_W-1:0]] <= s_sample;
        end
        rd_data_reg <= sample_mem[rd_idx_reg[IDX_W-1:0]];
    end

    assign m_valid      = m_valid_reg;
    assign m_normalized = m_norm_reg;
    assign m_max_value  = m_max_reg;
    assign m_min_value  = m_min_reg;
    assign m_mean_value = m_mean_reg;
    assign m_below_flag = m_below_reg;
    assign m_overflow   = m_over_reg;
    assign m_last_out   = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("sample count exceeds buffer depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above running maximum");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input still open after the last beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normalized <= NORM_W'(1 << FRAC_W)))
        else $error("normalized value above one");

endmodule
